@@ hdl/e2a_pkg.sv @@
// Shared constants, types and the arctangent table of the coordinate converter.
`default_nettype none
package e2a_pkg;

  localparam int ATAN_LEN = 24;
  localparam int NSQ      = 32;

  localparam logic [30:0] K_DAY     = 31'd1058355104;
  localparam logic [36:0] C_BASE    = 37'd107868103639;
  localparam logic [32:0] GAIN_INF  = 33'd652032874;
  localparam logic [32:0] GAIN_CORR = 33'd434688583;

  localparam logic signed [33:0] DEG90  = 34'sd1509949440;
  localparam logic signed [33:0] DEG180 = 34'sd3019898880;
  localparam logic signed [33:0] DEG360 = 34'sd6039797760;

  localparam logic CFG_LATITUDE  = 1'b0;
  localparam logic CFG_LONGITUDE = 1'b1;

  typedef struct packed {
    logic        [18:0] ra;
    logic signed [17:0] dec;
    logic signed [17:0] lat;
    logic signed [26:0] days;
    logic signed [20:0] off;
    logic signed [63:0] prod;
    logic        [45:0] low;
    logic        [25:0] lst;
    logic        [25:0] decm;
    logic        [25:0] latm;
    logic        [25:0] ha;
    logic        [2:0]  neg;
    logic signed [32:0] sd;
    logic signed [32:0] cd;
    logic signed [32:0] sl;
    logic signed [32:0] cl;
    logic signed [32:0] sh;
    logic signed [32:0] ch;
    logic signed [63:0] p1;
    logic signed [63:0] p2;
    logic signed [63:0] p3;
    logic signed [32:0] t1;
    logic signed [32:0] sa;
    logic signed [63:0] sq;
    logic signed [63:0] p4;
    logic signed [33:0] num;
    logic signed [32:0] ca;
    logic signed [63:0] p5;
    logic signed [33:0] den;
    logic signed [63:0] dd;
    logic signed [63:0] nn;
    logic               zen;
    logic               skip;
    logic               ge;
    logic               le;
  } item_t;

  // atan(2^-i) in 2^-24 degree.
  function automatic logic [32:0] atan_at(input int idx);
    logic [32:0] v;
    case (idx)
      0: v = 33'd754974720;
      1: v = 33'd445687602;
      2: v = 33'd235489089;
      3: v = 33'd119537938;
      4: v = 33'd60000934;
      5: v = 33'd30029717;
      6: v = 33'd15018523;
      7: v = 33'd7509720;
      8: v = 33'd3754917;
      9: v = 33'd1877466;
      10: v = 33'd938734;
      11: v = 33'd469367;
      12: v = 33'd234683;
      13: v = 33'd117342;
      14: v = 33'd58671;
      15: v = 33'd29335;
      16: v = 33'd14668;
      17: v = 33'd7334;
      18: v = 33'd3667;
      19: v = 33'd1833;
      20: v = 33'd917;
      21: v = 33'd458;
      22: v = 33'd229;
      23: v = 33'd115;
      default: v = 33'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

@@ hdl/e2a_sub_cell.sv @@
// Modulo reduction cell: conditionally subtracts a fixed multiple on each lane.
`default_nettype none
module e2a_sub_cell #(
  parameter int LANES = 1,
  parameter int W = 44,
  parameter int SW = 1,
  parameter logic [LANES-1:0][W-1:0] SUBS = '0
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      en_i,
  input  wire logic                      valid_i,
  input  wire logic [SW-1:0]             side_i,
  input  wire logic [LANES-1:0][W-1:0]   r_i,
  output logic                           valid_o,
  output logic [SW-1:0]                  side_o,
  output logic [LANES-1:0][W-1:0]        r_o
);

  logic                    valid_q;
  logic [SW-1:0]           side_q;
  logic [LANES-1:0][W-1:0] r_q, r_d;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      if (r_i[l] >= SUBS[l]) begin
        r_d[l] = r_i[l] - SUBS[l];
      end else begin
        r_d[l] = r_i[l];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q <= side_i;
      r_q    <= r_d;
    end
  end

  assign valid_o = valid_q;
  assign side_o  = side_q;
  assign r_o     = r_q;

endmodule
`default_nettype wire

@@ hdl/e2a_rot_cell.sv @@
// CORDIC rotation cell: one micro-rotation per lane toward a zero residual angle.
`default_nettype none
module e2a_rot_cell #(
  parameter int LANES = 1,
  parameter int SW = 1,
  parameter int SHIFT = 0,
  parameter logic [32:0] ATAN = 33'd0
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     en_i,
  input  wire logic                     valid_i,
  input  wire logic [SW-1:0]            side_i,
  input  wire logic [LANES-1:0][32:0]   x_i,
  input  wire logic [LANES-1:0][32:0]   y_i,
  input  wire logic [LANES-1:0][32:0]   z_i,
  output logic                          valid_o,
  output logic [SW-1:0]                 side_o,
  output logic [LANES-1:0][32:0]        x_o,
  output logic [LANES-1:0][32:0]        y_o,
  output logic [LANES-1:0][32:0]        z_o
);

  logic                   valid_q;
  logic [SW-1:0]          side_q;
  logic [LANES-1:0][32:0] x_q, y_q, z_q, x_d, y_d, z_d;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      if (!z_i[l][32]) begin
        x_d[l] = x_i[l] - 33'($signed(y_i[l]) >>> SHIFT);
        y_d[l] = y_i[l] + 33'($signed(x_i[l]) >>> SHIFT);
        z_d[l] = z_i[l] - ATAN;
      end else begin
        x_d[l] = x_i[l] + 33'($signed(y_i[l]) >>> SHIFT);
        y_d[l] = y_i[l] - 33'($signed(x_i[l]) >>> SHIFT);
        z_d[l] = z_i[l] + ATAN;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q <= side_i;
      x_q    <= x_d;
      y_q    <= y_d;
      z_q    <= z_d;
    end
  end

  assign valid_o = valid_q;
  assign side_o  = side_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign z_o     = z_q;

endmodule
`default_nettype wire

@@ hdl/e2a_vec_cell.sv @@
// CORDIC vectoring cell: one micro-rotation per lane driving y toward zero.
`default_nettype none
module e2a_vec_cell #(
  parameter int LANES = 1,
  parameter int SW = 1,
  parameter int SHIFT = 0,
  parameter logic [32:0] ATAN = 33'd0
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     en_i,
  input  wire logic                     valid_i,
  input  wire logic [SW-1:0]            side_i,
  input  wire logic [LANES-1:0][32:0]   x_i,
  input  wire logic [LANES-1:0][32:0]   y_i,
  input  wire logic [LANES-1:0][32:0]   z_i,
  output logic                          valid_o,
  output logic [SW-1:0]                 side_o,
  output logic [LANES-1:0][32:0]        x_o,
  output logic [LANES-1:0][32:0]        y_o,
  output logic [LANES-1:0][32:0]        z_o
);

  logic                   valid_q;
  logic [SW-1:0]          side_q;
  logic [LANES-1:0][32:0] x_q, y_q, z_q, x_d, y_d, z_d;

  // Once y reaches zero the lane holds its values for the rest of the chain.
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      if (!y_i[l][32] && (y_i[l] != 33'd0)) begin
        x_d[l] = x_i[l] + 33'($signed(y_i[l]) >>> SHIFT);
        y_d[l] = y_i[l] - 33'($signed(x_i[l]) >>> SHIFT);
        z_d[l] = z_i[l] + ATAN;
      end else if (y_i[l][32]) begin
        x_d[l] = x_i[l] - 33'($signed(y_i[l]) >>> SHIFT);
        y_d[l] = y_i[l] + 33'($signed(x_i[l]) >>> SHIFT);
        z_d[l] = z_i[l] - ATAN;
      end else begin
        x_d[l] = x_i[l];
        y_d[l] = y_i[l];
        z_d[l] = z_i[l];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q <= side_i;
      x_q    <= x_d;
      y_q    <= y_d;
      z_q    <= z_d;
    end
  end

  assign valid_o = valid_q;
  assign side_o  = side_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign z_o     = z_q;

endmodule
`default_nettype wire

@@ hdl/e2a_sqrt_cell.sv @@
// Integer square root cell: resolves one root bit per cycle while en_i is high.
`default_nettype none
module e2a_sqrt_cell #(
  parameter int SW = 1,
  parameter int K = 0
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire logic          valid_i,
  input  wire logic [SW-1:0] side_i,
  input  wire logic [63:0]   v_i,
  input  wire logic [63:0]   r_i,
  output logic               valid_o,
  output logic [SW-1:0]      side_o,
  output logic [63:0]        v_o,
  output logic [63:0]        r_o
);

  localparam logic [63:0] BITV = 64'd1 << (2 * K);

  logic          valid_q;
  logic [SW-1:0] side_q;
  logic [63:0]   v_q, r_q, v_d, r_d, trial;

  always_comb begin
    trial = r_i + BITV;
    if (v_i >= trial) begin
      v_d = v_i - trial;
      r_d = (r_i >> 1) + BITV;
    end else begin
      v_d = v_i;
      r_d = r_i >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q <= side_i;
      v_q    <= v_d;
      r_q    <= r_d;
    end
  end

  assign valid_o = valid_q;
  assign side_o  = side_q;
  assign v_o     = v_q;
  assign r_o     = r_q;

endmodule
`default_nettype wire

@@ hdl/equatorial_to_altaz.sv @@
// Equatorial to horizontal coordinate converter, top level.
// Built from the modulo reduction chains, two CORDIC chains and two 32-cell root chains,
// with product registers between them and a registered output.
// Throughput: one transaction per cycle; the whole pipeline holds while the output stalls.
// Reset clears all valid bits and sets both observer registers to zero.
`default_nettype none
module equatorial_to_altaz #(
  parameter int FRAC_BITS = 10,
  parameter int CORDIC_STAGES = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_addr_i,
  input  wire logic [18:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [18:0] right_ascension_i,
  input  wire logic [17:0] declination_i,
  input  wire logic [26:0] days_since_epoch_i,
  input  wire logic [14:0] universal_hours_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [17:0]      altitude_o,
  output logic [18:0]      azimuth_o,
  output logic [18:0]      hour_angle_o,
  output logic [18:0]      sidereal_angle_o,
  output logic             at_zenith_o
);

  import e2a_pkg::*;

  localparam int FULL = 360 << FRAC_BITS;
  localparam int HW   = 34 - FRAC_BITS;
  localparam int NMA  = HW + 1;
  localparam int NCOR = (CORDIC_STAGES > ATAN_LEN) ? ATAN_LEN : CORDIC_STAGES;
  localparam int DOWN = 24 - FRAC_BITS;
  localparam int SW   = $bits(item_t);
  localparam logic [32:0] XINIT = GAIN_INF + (GAIN_CORR >> (2 * NCOR));
  localparam logic [43:0] FULL44 = 44'(FULL);
  localparam logic [63:0] LOWMASK = (64'd1 << (FRAC_BITS + 30)) - 64'd1;
  localparam logic signed [63:0] CB = 64'(C_BASE) << FRAC_BITS;
  localparam logic signed [63:0] HALFQ = 64'sd536870912;
  localparam logic signed [33:0] ONEQ = 34'sd1073741824;
  localparam logic signed [33:0] HALFD = 34'sd1 <<< (DOWN - 1);
  localparam logic signed [33:0] FULLS = 34'(FULL);

  logic        en;
  logic [17:0] lat_q;
  logic [18:0] lon_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lat_q <= '0;
      lon_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_LATITUDE:  lat_q <= cfg_wdata_i[17:0];
        CFG_LONGITUDE: lon_q <= cfg_wdata_i;
        default:       lat_q <= lat_q;
      endcase
    end
  end

  logic out_valid_q;
  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  // Input and product stages.
  item_t s1_d, s1_q, s2_d, s2_q;
  logic  s1v_q, s2v_q;

  always_comb begin
    s1_d      = '0;
    s1_d.ra   = right_ascension_i;
    s1_d.dec  = declination_i;
    s1_d.lat  = lat_q;
    s1_d.days = days_since_epoch_i;
    s1_d.off  = $signed({2'b00, 19'(universal_hours_i) * 19'd15})
              - $signed({{2{lon_q[18]}}, lon_q});
    s2_d      = s1_q;
    s2_d.prod = 64'($signed(s1_q.days) * $signed({1'b0, K_DAY}));
  end

  // Sidereal sum; the integer degree part and both raw angles enter the first reduction.
  logic signed [63:0] sum, offx, hsum;
  item_t              a_in;
  logic [2:0][43:0]   a_rin;

  always_comb begin
    offx     = 64'(s2_q.off);
    sum      = CB + s2_q.prod + (offx <<< 30);
    hsum     = sum >>> (FRAC_BITS + 30);
    a_in     = s2_q;
    a_in.low = 46'(sum & LOWMASK);
    a_rin[0] = 44'(hsum) + (44'd360 << HW);
    a_rin[1] = 44'(s2_q.dec) + (FULL44 << HW);
    a_rin[2] = 44'(s2_q.lat) + (FULL44 << HW);
  end

  logic [NMA:0]              av;
  logic [NMA:0][SW-1:0]      aside;
  logic [NMA:0][2:0][43:0]   ar;

  assign av[0]    = s2v_q;
  assign aside[0] = a_in;
  assign ar[0]    = a_rin;

  for (genvar j = 0; j < NMA; j++) begin : g_moda
    e2a_sub_cell #(
      .LANES(3), .W(44), .SW(SW),
      .SUBS({FULL44 << (HW - j), FULL44 << (HW - j), 44'd360 << (HW - j)})
    ) u_cell (
      .clk_i(clk_i), .rst_ni(rst_ni), .en_i(en),
      .valid_i(av[j]), .side_i(aside[j]), .r_i(ar[j]),
      .valid_o(av[j+1]), .side_o(aside[j+1]), .r_o(ar[j+1])
    );
  end

  // Sidereal rounding and the raw hour angle.
  item_t       b_in, a_out;
  logic [63:0] lval, lstw;
  logic [0:0][43:0] b_rin;

  always_comb begin
    a_out     = item_t'(aside[NMA]);
    lval      = (64'(ar[NMA][0]) << (FRAC_BITS + 30)) + 64'(a_out.low);
    lstw      = (lval + 64'd536870912) >> 30;
    if (lstw >= 64'(FULL)) begin
      lstw = lstw - 64'(FULL);
    end
    b_in      = a_out;
    b_in.lst  = 26'(lstw);
    b_in.decm = 26'(ar[NMA][1]);
    b_in.latm = 26'(ar[NMA][2]);
    b_rin[0]  = 44'(lstw) - 44'(a_out.ra) + (FULL44 << HW);
  end

  logic [NMA:0]              bv;
  logic [NMA:0][SW-1:0]      bside;
  logic [NMA:0][0:0][43:0]   br;

  assign bv[0]    = av[NMA];
  assign bside[0] = b_in;
  assign br[0]    = b_rin;

  for (genvar j = 0; j < NMA; j++) begin : g_modb
    e2a_sub_cell #(
      .LANES(1), .W(44), .SW(SW), .SUBS(FULL44 << (HW - j))
    ) u_cell (
      .clk_i(clk_i), .rst_ni(rst_ni), .en_i(en),
      .valid_i(bv[j]), .side_i(bside[j]), .r_i(br[j]),
      .valid_o(bv[j+1]), .side_o(bside[j+1]), .r_o(br[j+1])
    );
  end

  // Quadrant folding ahead of the rotation chain.
  item_t              p_in;
  logic [2:0][25:0]   pang;
  logic signed [33:0] pz [3];
  logic [2:0][32:0]   px, py, pzv;

  always_comb begin
    p_in    = item_t'(bside[NMA]);
    p_in.ha = 26'(br[NMA][0]);
    pang[0] = p_in.decm;
    pang[1] = p_in.latm;
    pang[2] = p_in.ha;
    for (int l = 0; l < 3; l++) begin
      pz[l] = $signed(34'(pang[l]) << DOWN);
      p_in.neg[l] = 1'b0;
      if (pz[l] >= DEG180) begin
        pz[l] = pz[l] - DEG360;
      end
      if (pz[l] > DEG90) begin
        pz[l] = pz[l] - DEG180;
        p_in.neg[l] = 1'b1;
      end else if (pz[l] < -DEG90) begin
        pz[l] = pz[l] + DEG180;
        p_in.neg[l] = 1'b1;
      end
      px[l]  = XINIT;
      py[l]  = '0;
      pzv[l] = 33'(pz[l]);
    end
  end

  logic [NCOR:0]             rv;
  logic [NCOR:0][SW-1:0]     rside;
  logic [NCOR:0][2:0][32:0]  rx, ry, rz;

  assign rv[0]    = bv[NMA];
  assign rside[0] = p_in;
  assign rx[0]    = px;
  assign ry[0]    = py;
  assign rz[0]    = pzv;

  for (genvar j = 0; j < NCOR; j++) begin : g_rot
    e2a_rot_cell #(
      .LANES(3), .SW(SW), .SHIFT(j), .ATAN(atan_at(j))
    ) u_cell (
      .clk_i(clk_i), .rst_ni(rst_ni), .en_i(en),
      .valid_i(rv[j]), .side_i(rside[j]),
      .x_i(rx[j]), .y_i(ry[j]), .z_i(rz[j]),
      .valid_o(rv[j+1]), .side_o(rside[j+1]),
      .x_o(rx[j+1]), .y_o(ry[j+1]), .z_o(rz[j+1])
    );
  end

  // Product stages for the altitude sine and the azimuth numerator.
  item_t m1_d, m1_q, m2_d, m2_q, m3_d, m3_q, m4_d, m4_q;
  logic  m1v_q, m2v_q, m3v_q, m4v_q;
  logic signed [32:0] sv [3];
  logic signed [32:0] cv [3];
  logic signed [32:0] t2;
  logic signed [33:0] sat;

  always_comb begin
    m1_d = item_t'(rside[NCOR]);
    for (int l = 0; l < 3; l++) begin
      sv[l] = m1_d.neg[l] ? -$signed(ry[NCOR][l]) : $signed(ry[NCOR][l]);
      cv[l] = m1_d.neg[l] ? -$signed(rx[NCOR][l]) : $signed(rx[NCOR][l]);
    end
    m1_d.sd = sv[0];
    m1_d.cd = cv[0];
    m1_d.sl = sv[1];
    m1_d.cl = cv[1];
    m1_d.sh = sv[2];
    m1_d.ch = cv[2];
    m1_d.p1 = 64'(sv[0] * sv[1]);
    m1_d.p2 = 64'(cv[0] * cv[1]);

    m2_d    = m1_q;
    m2_d.t1 = 33'((m1_q.p1 + HALFQ) >>> 30);
    t2      = 33'((m1_q.p2 + HALFQ) >>> 30);
    m2_d.p3 = 64'(t2 * m1_q.ch);

    m3_d = m2_q;
    sat  = 34'(m2_q.t1) + 34'((m2_q.p3 + HALFQ) >>> 30);
    if (sat > ONEQ) begin
      sat = ONEQ;
    end
    if (sat < -ONEQ) begin
      sat = -ONEQ;
    end
    m3_d.sa = 33'(sat);

    m4_d    = m3_q;
    m4_d.sq = 64'(m3_q.sa * m3_q.sa);
    m4_d.p4 = 64'(m3_q.sa * m3_q.sl);
  end

  // Cosine of the altitude as the root of one minus its squared sine.
  item_t q_in;

  always_comb begin
    q_in     = m4_q;
    q_in.num = 34'(m4_q.sd) - 34'((m4_q.p4 + HALFQ) >>> 30);
  end

  logic [NSQ:0]            qv;
  logic [NSQ:0][SW-1:0]    qside;
  logic [NSQ:0][63:0]      qvv, qr;

  assign qv[0]    = m4v_q;
  assign qside[0] = q_in;
  assign qvv[0]   = (64'd1 << 60) - 64'(m4_q.sq);
  assign qr[0]    = '0;

  for (genvar j = 0; j < NSQ; j++) begin : g_sqrt1
    e2a_sqrt_cell #(.SW(SW), .K(NSQ - 1 - j)) u_cell (
      .clk_i(clk_i), .rst_ni(rst_ni), .en_i(en),
      .valid_i(qv[j]), .side_i(qside[j]), .v_i(qvv[j]), .r_i(qr[j]),
      .valid_o(qv[j+1]), .side_o(qside[j+1]), .v_o(qvv[j+1]), .r_o(qr[j+1])
    );
  end

  // Azimuth ratio: denominator, sign fix and squares for the second root.
  item_t d1_d, d1_q, d2_d, d2_q, d3_d, d3_q;
  logic  d1v_q, d2v_q, d3v_q;
  logic signed [33:0] dn;

  always_comb begin
    d1_d     = item_t'(qside[NSQ]);
    d1_d.ca  = 33'(qr[NSQ]);
    d1_d.zen = (qr[NSQ] == 64'd0);
    d1_d.p5  = 64'($signed(33'(qr[NSQ])) * d1_d.cl);

    d2_d = d1_q;
    dn   = 34'((d1_q.p5 + HALFQ) >>> 30);
    if (dn < 0) begin
      d2_d.den = -dn;
      d2_d.num = -d1_q.num;
    end else begin
      d2_d.den = dn;
    end

    d3_d      = d2_q;
    d3_d.dd   = 64'(d2_q.den * d2_q.den);
    d3_d.nn   = 64'(d2_q.num * d2_q.num);
    d3_d.ge   = (d2_q.num >= d2_q.den);
    d3_d.le   = (d2_q.num <= -d2_q.den);
    d3_d.skip = d2_q.zen || (d2_q.den == 34'sd0);
  end

  logic [NSQ:0]            uv;
  logic [NSQ:0][SW-1:0]    uside;
  logic [NSQ:0][63:0]      uvv, ur;

  assign uv[0]    = d3v_q;
  assign uside[0] = d3_q;
  assign uvv[0]   = (d3_q.ge || d3_q.le) ? 64'd0 : 64'(d3_q.dd - d3_q.nn);
  assign ur[0]    = '0;

  for (genvar j = 0; j < NSQ; j++) begin : g_sqrt2
    e2a_sqrt_cell #(.SW(SW), .K(NSQ - 1 - j)) u_cell (
      .clk_i(clk_i), .rst_ni(rst_ni), .en_i(en),
      .valid_i(uv[j]), .side_i(uside[j]), .v_i(uvv[j]), .r_i(ur[j]),
      .valid_o(uv[j+1]), .side_o(uside[j+1]), .v_o(uvv[j+1]), .r_o(ur[j+1])
    );
  end

  // Arctangent lanes: altitude from (sin, cos), azimuth from (root, |num|).
  item_t            w_in;
  logic [1:0][32:0] wx, wy, wz;

  always_comb begin
    w_in  = item_t'(uside[NSQ]);
    wx[0] = w_in.ca;
    wy[0] = w_in.sa;
    wx[1] = w_in.num[33] ? 33'(-w_in.num) : 33'(w_in.num);
    wy[1] = 33'(ur[NSQ]);
    wz    = '0;
  end

  logic [NCOR:0]             vv;
  logic [NCOR:0][SW-1:0]     vside;
  logic [NCOR:0][1:0][32:0]  vx, vy, vz;

  assign vv[0]    = uv[NSQ];
  assign vside[0] = w_in;
  assign vx[0]    = wx;
  assign vy[0]    = wy;
  assign vz[0]    = wz;

  for (genvar j = 0; j < NCOR; j++) begin : g_vec
    e2a_vec_cell #(
      .LANES(2), .SW(SW), .SHIFT(j), .ATAN(atan_at(j))
    ) u_cell (
      .clk_i(clk_i), .rst_ni(rst_ni), .en_i(en),
      .valid_i(vv[j]), .side_i(vside[j]),
      .x_i(vx[j]), .y_i(vy[j]), .z_i(vz[j]),
      .valid_o(vv[j+1]), .side_o(vside[j+1]),
      .x_o(vx[j+1]), .y_o(vy[j+1]), .z_o(vz[j+1])
    );
  end

  // Final rounding, mirror and output register.
  item_t              o_it;
  logic signed [33:0] altw, theta, thr, azw;
  logic [17:0]        alt_d, alt_q;
  logic [18:0]        az_d, az_q, ha_q, lst_q;
  logic               zen_q;

  always_comb begin
    o_it = item_t'(vside[NCOR]);
    altw = ($signed(34'($signed(vz[NCOR][0]))) + HALFD) >>> DOWN;
    if (o_it.ge) begin
      theta = '0;
    end else if (o_it.le) begin
      theta = DEG180;
    end else if (o_it.num[33]) begin
      theta = DEG180 - 34'($signed(vz[NCOR][1]));
    end else begin
      theta = 34'($signed(vz[NCOR][1]));
    end
    thr = (theta + HALFD) >>> DOWN;
    azw = o_it.sh[32] ? thr : FULLS - thr;
    if (azw >= FULLS) begin
      azw = azw - FULLS;
    end
    if (azw < 0) begin
      azw = azw + FULLS;
    end
    if (o_it.skip) begin
      azw = '0;
    end
    alt_d = 18'(altw);
    az_d  = 19'(azw);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1v_q       <= 1'b0;
      s2v_q       <= 1'b0;
      m1v_q       <= 1'b0;
      m2v_q       <= 1'b0;
      m3v_q       <= 1'b0;
      m4v_q       <= 1'b0;
      d1v_q       <= 1'b0;
      d2v_q       <= 1'b0;
      d3v_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      s1v_q       <= in_valid_i;
      s2v_q       <= s1v_q;
      m1v_q       <= rv[NCOR];
      m2v_q       <= m1v_q;
      m3v_q       <= m2v_q;
      m4v_q       <= m3v_q;
      d1v_q       <= qv[NSQ];
      d2v_q       <= d1v_q;
      d3v_q       <= d2v_q;
      out_valid_q <= vv[NCOR];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q  <= s1_d;
      s2_q  <= s2_d;
      m1_q  <= m1_d;
      m2_q  <= m2_d;
      m3_q  <= m3_d;
      m4_q  <= m4_d;
      d1_q  <= d1_d;
      d2_q  <= d2_d;
      d3_q  <= d3_d;
      alt_q <= alt_d;
      az_q  <= az_d;
      ha_q  <= 19'(o_it.ha);
      lst_q <= 19'(o_it.lst);
      zen_q <= o_it.zen;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign altitude_o       = alt_q;
  assign azimuth_o        = az_q;
  assign hour_angle_o     = ha_q;
  assign sidereal_angle_o = lst_q;
  assign at_zenith_o      = zen_q;

endmodule
`default_nettype wire
